>>> rtl/core/bdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types, request and status codes and cell commands for the bounded array deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int VALUE_W   = 32;
    localparam int REQ_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int CMD_W     = 3;
    localparam int S_TDATA_W = VALUE_W;
    localparam int S_TUSER_W = REQ_W;
    localparam int M_TUSER_W = STATUS_W + 1;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DUMP       = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    // cell commands
    localparam logic [CMD_W-1:0] CMD_HOLD       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SHIFT_UP   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SHIFT_DOWN = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ROTATE     = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
    } cell_ctrl_t;

endpackage

>>> rtl/core/bdq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_cell
// One storage slot of the deque: holds, loads, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module bdq_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 4
) (
    input  logic                         aclk,
    input  bdq_pkg::cell_ctrl_t          ctrl,
    input  logic [CNT_W-1:0]             count,
    input  logic [bdq_pkg::VALUE_W-1:0]  lower_data,
    input  logic [bdq_pkg::VALUE_W-1:0]  upper_data,
    input  logic [bdq_pkg::VALUE_W-1:0]  head_data,
    output logic [bdq_pkg::VALUE_W-1:0]  data
);

    localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);

    logic [bdq_pkg::VALUE_W-1:0] data_reg;
    logic [bdq_pkg::VALUE_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (ctrl.cmd)
            bdq_pkg::CMD_APPEND: begin
                if (count == MY_IDX) begin
                    data_next = ctrl.value;
                end
            end
            bdq_pkg::CMD_SHIFT_UP: begin
                data_next = (IDX == 0) ? ctrl.value : lower_data;
            end
            bdq_pkg::CMD_SHIFT_DOWN: begin
                data_next = upper_data;
            end
            bdq_pkg::CMD_ROTATE: begin
                // the tail slot of the occupied run takes the head back
                data_next = (count == MY_NEXT) ? head_data : upper_data;
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> rtl/core/bounded_array_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_deque
// Fixed-depth deque built as a row of shifting cells with an occupancy count.
// ----------------------------------------------------------------------------
// channel | dir | ports          | content
// s_      | in  | tdata, tuser   | request: value, req_type
// m_      | out | tdata, tuser,  | result: entry_value, occupancy, status,
//         |     | tlast          | entry_valid, last
//
// push_front and pop_front shift all cells together, push_back writes the cell
// at the count, pop_back only lowers it. a dump enters the dump state, then
// gives one result per held entry, rotating the occupied cells so entry 0 is
// always read from the first cell. reset clears the state, count and output
// valid; cell contents and output data are undefined. a stalled result holds
// the block; while idle, an item is taken when the output is empty or taken.
// ----------------------------------------------------------------------------
module bounded_array_deque #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF,
    localparam int OCC_W = $clog2(DEPTH + 1),
    localparam int M_TDATA_W = ((bdq_pkg::VALUE_W + OCC_W + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bdq_pkg::S_TDATA_W-1:0]   s_tdata,   // value
    input  logic [bdq_pkg::S_TUSER_W-1:0]   s_tuser,   // req_type
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [M_TDATA_W-1:0]            m_tdata,   // entry_value, occupancy
    output logic [bdq_pkg::M_TUSER_W-1:0]   m_tuser,   // status, entry_valid
    output logic                            m_tlast
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;
    localparam logic [OCC_W-1:0] FULL_CNT = OCC_W'(DEPTH);
    localparam logic [OCC_W-1:0] ONE_CNT  = OCC_W'(1);

    logic                            state_reg, state_next;
    logic [OCC_W-1:0]                count_reg, count_next;
    logic [OCC_W-1:0]                left_reg, left_next;
    logic                            m_valid_reg, m_valid_next;
    logic [bdq_pkg::STATUS_W-1:0]    m_status_reg, m_status_next;
    logic                            m_ev_reg, m_ev_next;
    logic [bdq_pkg::VALUE_W-1:0]     m_value_reg, m_value_next;
    logic [OCC_W-1:0]                m_occ_reg, m_occ_next;
    logic                            m_last_reg, m_last_next;
    logic                            load;

    logic                            out_free;
    logic                            accept;
    logic                            full;
    logic                            empty;
    bdq_pkg::cell_ctrl_t             ctrl;
    logic [bdq_pkg::VALUE_W-1:0]     cell_data [DEPTH];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        left_next     = left_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        load          = 1'b0;
        m_status_next = bdq_pkg::STAT_OK;
        m_ev_next     = 1'b0;
        m_value_next  = '0;
        m_last_next   = 1'b1;
        ctrl.cmd      = bdq_pkg::CMD_HOLD;
        ctrl.value    = s_tdata;

        if (accept) begin
            load = 1'b1;
            case (s_tuser)
                bdq_pkg::REQ_PUSH_BACK: begin
                    if (full) begin
                        m_status_next = bdq_pkg::STAT_FULL;
                    end else begin
                        ctrl.cmd   = bdq_pkg::CMD_APPEND;
                        count_next = count_reg + ONE_CNT;
                    end
                end
                bdq_pkg::REQ_POP_BACK: begin
                    if (empty) begin
                        m_status_next = bdq_pkg::STAT_EMPTY;
                    end else begin
                        count_next = count_reg - ONE_CNT;
                    end
                end
                bdq_pkg::REQ_PUSH_FRONT: begin
                    if (full) begin
                        m_status_next = bdq_pkg::STAT_FULL;
                    end else begin
                        ctrl.cmd   = bdq_pkg::CMD_SHIFT_UP;
                        count_next = count_reg + ONE_CNT;
                    end
                end
                bdq_pkg::REQ_POP_FRONT: begin
                    if (empty) begin
                        m_status_next = bdq_pkg::STAT_EMPTY;
                    end else begin
                        ctrl.cmd   = bdq_pkg::CMD_SHIFT_DOWN;
                        count_next = count_reg - ONE_CNT;
                    end
                end
                bdq_pkg::REQ_DUMP: begin
                    if (empty) begin
                        m_status_next = bdq_pkg::STAT_EMPTY;
                    end else begin
                        // results come out of the dump state
                        load       = 1'b0;
                        state_next = ST_DUMP;
                        left_next  = count_reg;
                    end
                end
                default: begin
                    m_status_next = bdq_pkg::STAT_OK;
                end
            endcase
            m_valid_next = m_valid_next || load;
        end else if (state_reg == ST_DUMP && out_free) begin
            load         = 1'b1;
            m_valid_next = 1'b1;
            m_ev_next    = 1'b1;
            m_value_next = cell_data[0];
            m_last_next  = (left_reg == ONE_CNT);
            ctrl.cmd     = bdq_pkg::CMD_ROTATE;
            left_next    = left_reg - ONE_CNT;
            if (left_reg == ONE_CNT) begin
                state_next = ST_IDLE;
            end
        end
        m_occ_next = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            left_reg    <= left_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_status_reg <= m_status_next;
            m_ev_reg     <= m_ev_next;
            m_value_reg  <= m_value_next;
            m_occ_reg    <= m_occ_next;
            m_last_reg   <= m_last_next;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            localparam int LO = (gi == 0) ? 0 : gi - 1;
            localparam int HI = (gi == DEPTH - 1) ? 0 : gi + 1;
            bdq_cell #(
                .IDX   (gi),
                .CNT_W (OCC_W)
            ) u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .count      (count_reg),
                .lower_data (cell_data[LO]),
                .upper_data (cell_data[HI]),
                .head_data  (cell_data[0]),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_occ_reg, m_value_reg});
    assign m_tuser  = {m_ev_reg, m_status_reg};
    assign m_tlast  = m_last_reg;

endmodule

>>> rtl/core/bdq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks on the bounded array deque, bound to the top level.
// ----------------------------------------------------------------------------
module bdq_checker #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF,
    localparam int OCC_W = $clog2(DEPTH + 1),
    localparam int M_TDATA_W = ((bdq_pkg::VALUE_W + OCC_W + 7) / 8) * 8
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [M_TDATA_W-1:0]            m_tdata,
    input logic [bdq_pkg::M_TUSER_W-1:0]   m_tuser,
    input logic                            m_tlast
);

    localparam int OCC_LO = bdq_pkg::VALUE_W;
    localparam int OCC_HI = bdq_pkg::VALUE_W + OCC_W - 1;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // no new item while a result is stuck in the output register
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("item taken while output stalled");

    // only dump entries can be followed by more results of the same item
    a_last_nondump: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[bdq_pkg::STATUS_W] |-> m_tlast)
        else $error("non-entry result without last");

    // an empty result never carries an entry
    a_empty_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[bdq_pkg::STATUS_W-1:0] == bdq_pkg::STAT_EMPTY
            |-> !m_tuser[bdq_pkg::STATUS_W] && m_tdata[bdq_pkg::VALUE_W-1:0] == '0)
        else $error("empty result carries data");

    a_occ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OCC_HI:OCC_LO] <= OCC_W'(DEPTH))
        else $error("occupancy above depth");

endmodule

bind bounded_array_deque bdq_checker #(.DEPTH(DEPTH)) u_bdq_checker (.*);
